// File: rtl/slow_data_deframer_macros.svh
// ----------------------------------------------------------------------------
// slow data deframer assertion macros
// shared concurrent assertion forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef SLOW_DATA_DEFRAMER_MACROS_SVH
`define SLOW_DATA_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SDD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// invariant that holds on every edge
`define SDD_ASSERT_ALWAYS(lbl, cond, msg) `SDD_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

// File: rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// types and constants shared by the slow data deframer modules
// ----------------------------------------------------------------------------
package sdd_pkg;

  // sizes
  localparam int NUM_LANES    = 5;
  localparam int HEAD_LEN     = 5;
  localparam int MSG_LEN      = 20;
  localparam int RUN_MAX      = 20;
  localparam int LINE_RUN_MAX = NUM_LANES + 2;
  localparam int RUN_CNT_W    = $clog2(RUN_MAX + 1);

  // descrambling key
  localparam logic [7:0] KEY_A = 8'h70;
  localparam logic [7:0] KEY_B = 8'h4F;
  localparam logic [7:0] KEY_C = 8'h93;

  // mini-header codes
  localparam logic [7:0] HDR_MSG_FIRST  = 8'h40;
  localparam logic [7:0] HDR_MSG_LAST   = 8'h43;
  localparam logic [7:0] HDR_LINE_FIRST = 8'h31;
  localparam logic [7:0] HDR_LINE_LAST  = 8'h35;

  // characters
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_R      = 8'h52;

  // longest line that is dropped for its length
  localparam logic [8:0] LINE_MIN_DROP = 9'd6;

  typedef enum logic [1:0] {
    KIND_MSG_CHAR  = 2'd0,
    KIND_LINE_BYTE = 2'd1,
    KIND_LINE_END  = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    CLASS_DROPPED  = 2'd0,
    CLASS_CRC      = 2'd1,
    CLASS_POSITION = 2'd2
  } line_class_t;

  // one result item
  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  pos;
    logic [7:0]  val;
    line_class_t cls;
  } result_t;

  // what one lane finds for its data byte
  typedef struct packed {
    logic                act;
    logic [8:0]          pos;
    logic [7:0]          val;
    logic [HEAD_LEN-1:0] head_hit;
  } lane_t;

  // merged line update
  typedef struct packed {
    logic [7:0]                    ptr;
    logic [HEAD_LEN-1:0][7:0]      head;
    logic [2:0]                    num;
    result_t [LINE_RUN_MAX-1:0]    ent;
  } line_upd_t;

endpackage

// File: rtl/sdd_lane.sv
// ----------------------------------------------------------------------------
// sdd_lane
// one line-byte lane: activity, line position and line head hits of one byte
// ----------------------------------------------------------------------------
module sdd_lane (
  input  logic [2:0]     lane_idx,
  input  logic [2:0]     cnt,
  input  logic [7:0]     ptr,
  input  logic [7:0]     data,
  output sdd_pkg::lane_t lane
);

  // position and head match of this byte
  always_comb begin
    lane.act = lane_idx < cnt;
    lane.pos = {1'b0, ptr} + {6'b0, lane_idx};
    lane.val = data;
    for (int j = 0; j < sdd_pkg::HEAD_LEN; j++) begin
      lane.head_hit[j] = lane.act && (lane.pos == 9'(j));
    end
  end

endmodule

// File: rtl/sdd_merge.sv
// ----------------------------------------------------------------------------
// sdd_merge
// combines the lanes: cr/lf handling, line head, class, pointer and results
// ----------------------------------------------------------------------------
module sdd_merge #(
  parameter int LINE_LIMIT = 240
) (
  input  sdd_pkg::lane_t [sdd_pkg::NUM_LANES-1:0]   lanes,
  input  logic [2:0]                                cnt,
  input  logic [7:0]                                ptr,
  input  logic [sdd_pkg::HEAD_LEN-1:0][7:0]         head_in,
  output sdd_pkg::line_upd_t                        upd
);

  logic                              cr;
  logic                              lf_end;
  logic [7:0]                        last;
  logic [8:0]                        ptr_cnt;
  logic [8:0]                        ptr_after;
  logic [7:0]                        len;
  logic [3:0]                        end_idx;
  logic                              is_crc;
  sdd_pkg::line_class_t              cls;
  logic [sdd_pkg::HEAD_LEN-1:0][7:0] head_nxt;

  // last byte of the chunk and line end detection
  always_comb begin
    last = '0;
    for (int i = 0; i < sdd_pkg::NUM_LANES; i++) begin
      if (lanes[i].act) begin
        last = lanes[i].val;
      end
    end
    cr        = (last == sdd_pkg::CHAR_CR);
    lf_end    = cr || (last == sdd_pkg::CHAR_LF);
    ptr_cnt   = {1'b0, ptr} + {6'b0, cnt};
    ptr_after = ptr_cnt + {8'b0, cr};
    len       = ptr_after[8] ? 8'hFF : ptr_after[7:0];
    end_idx   = {1'b0, cnt} + {3'b0, cr};
  end

  // line head after this chunk, inserted lf included
  always_comb begin
    for (int j = 0; j < sdd_pkg::HEAD_LEN; j++) begin
      head_nxt[j] = head_in[j];
      for (int i = 0; i < sdd_pkg::NUM_LANES; i++) begin
        if (lanes[i].head_hit[j]) begin
          head_nxt[j] = lanes[i].val;
        end
      end
      if (cr && (ptr_cnt == 9'(j))) begin
        head_nxt[j] = sdd_pkg::CHAR_LF;
      end
    end
  end

  // line classification
  always_comb begin
    is_crc = (head_nxt[0] == sdd_pkg::CHAR_DOLLAR) && (head_nxt[1] == sdd_pkg::CHAR_DOLLAR) &&
             (head_nxt[2] == sdd_pkg::CHAR_C) && (head_nxt[3] == sdd_pkg::CHAR_R) &&
             (head_nxt[4] == sdd_pkg::CHAR_C);
    priority if (ptr_after <= sdd_pkg::LINE_MIN_DROP) begin
      cls = sdd_pkg::CLASS_DROPPED;
    end else if (is_crc) begin
      cls = sdd_pkg::CLASS_CRC;
    end else if (head_nxt[0] == sdd_pkg::CHAR_LF) begin
      cls = sdd_pkg::CLASS_DROPPED;
    end else begin
      cls = sdd_pkg::CLASS_POSITION;
    end
  end

  // pointer, head and result list
  always_comb begin
    upd.head = head_nxt;
    if (lf_end) begin
      upd.ptr = '0;
    end else if (ptr_after > 9'(LINE_LIMIT)) begin
      upd.ptr = 8'(LINE_LIMIT);
    end else begin
      upd.ptr = ptr_after[7:0];
    end
    upd.num = cnt + {2'b0, cr} + {2'b0, lf_end};
    for (int k = 0; k < sdd_pkg::LINE_RUN_MAX; k++) begin
      upd.ent[k].kind = sdd_pkg::KIND_LINE_BYTE;
      upd.ent[k].pos  = '0;
      upd.ent[k].val  = '0;
      upd.ent[k].cls  = sdd_pkg::CLASS_DROPPED;
    end
    for (int k = 0; k < sdd_pkg::NUM_LANES; k++) begin
      upd.ent[k].pos = lanes[k].pos[7:0];
      upd.ent[k].val = lanes[k].val;
    end
    for (int k = 0; k < sdd_pkg::LINE_RUN_MAX; k++) begin
      if (cr && (3'(k) == cnt)) begin
        upd.ent[k].pos = ptr_cnt[7:0];
        upd.ent[k].val = sdd_pkg::CHAR_LF;
      end
      if (lf_end && (4'(k) == end_idx)) begin
        upd.ent[k].kind = sdd_pkg::KIND_LINE_END;
        upd.ent[k].pos  = len;
        upd.ent[k].val  = '0;
        upd.ent[k].cls  = cls;
      end
    end
  end

endmodule

// File: rtl/sdd_emit.sv
// ----------------------------------------------------------------------------
// sdd_emit
// result buffer that shifts out one result a cycle into an output register while it is free or being taken
// ----------------------------------------------------------------------------
module sdd_emit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      load,
  input  logic [sdd_pkg::RUN_CNT_W-1:0]             load_num,
  input  sdd_pkg::result_t [sdd_pkg::RUN_MAX-1:0]   load_ent,
  output logic                                      can_load,
  output logic [sdd_pkg::RUN_CNT_W-1:0]             fill,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output sdd_pkg::result_t                          out_ent,
  output logic                                      out_last
);

  sdd_pkg::result_t [sdd_pkg::RUN_MAX-1:0] ent_r, ent_nxt;
  logic [sdd_pkg::RUN_CNT_W-1:0]           num_r, num_nxt;
  logic                                    out_vld_r, out_vld_nxt;
  sdd_pkg::result_t                        out_ent_r, out_ent_nxt;
  logic                                    out_last_r, out_last_nxt;
  logic                                    move;

  // advance when the output register is free or being taken
  assign move     = (num_r != '0) && (!out_vld_r || out_tready);
  assign can_load = (num_r == '0) || ((num_r == sdd_pkg::RUN_CNT_W'(1)) && move);

  // next buffer and output register
  always_comb begin
    ent_nxt      = ent_r;
    num_nxt      = num_r;
    out_vld_nxt  = out_vld_r;
    out_ent_nxt  = out_ent_r;
    out_last_nxt = out_last_r;
    if (move) begin
      out_vld_nxt  = 1'b1;
      out_ent_nxt  = ent_r[0];
      out_last_nxt = (num_r == sdd_pkg::RUN_CNT_W'(1));
      for (int k = 0; k < sdd_pkg::RUN_MAX - 1; k++) begin
        ent_nxt[k] = ent_r[k+1];
      end
      num_nxt = num_r - sdd_pkg::RUN_CNT_W'(1);
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (load) begin
      ent_nxt = load_ent;
      num_nxt = load_num;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      num_r     <= num_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    out_ent_r  <= out_ent_nxt;
    out_last_r <= out_last_nxt;
  end

  assign fill       = num_r;
  assign out_tvalid = out_vld_r;
  assign out_ent    = out_ent_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/slow_data_deframer.sv
// ----------------------------------------------------------------------------
// slow_data_deframer: an accepted request's results go through the result buffer, then the output register
// a frame with n results holds the result buffer until all n are shifted out (message 20, line up to 7)
// frames without results are taken one per cycle while the buffer is free
// reset: synchronous active low, all state but the emit payload registers cleared to zero at once
// ----------------------------------------------------------------------------
`include "slow_data_deframer_macros.svh"

module slow_data_deframer #(
  parameter int LINE_LIMIT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // frame_seq, seg_byte_a, seg_byte_b, seg_byte_c
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // position, byte_value, line_class
  output logic [1:0]  out_tuser,   // item_kind
  output logic        out_tlast    // last_of_run
);

  logic [4:0]  seq;
  logic [7:0]  d0, d1, d2;
  logic        in_acc;
  logic        odd_frame;
  logic        even_frame;
  logic        is_msg;
  logic        is_line;
  logic        msg_emit;
  logic [2:0]  line_cnt;

  logic [7:0]                                   hdr_r, hdr_nxt;
  logic [sdd_pkg::NUM_LANES-1:0][7:0]           bb_r, bb_nxt;
  logic [sdd_pkg::NUM_LANES-1:0][7:0]           bb_cur;
  logic [sdd_pkg::MSG_LEN-1:0][7:0]             msg_r, msg_nxt;
  logic [7:0]                                   line_ptr_r, line_ptr_nxt;
  logic [sdd_pkg::HEAD_LEN-1:0][7:0]            head_r, head_nxt;

  sdd_pkg::lane_t [sdd_pkg::NUM_LANES-1:0]      lanes;
  sdd_pkg::line_upd_t                           upd;
  sdd_pkg::result_t [sdd_pkg::RUN_MAX-1:0]      run_ent;
  logic [sdd_pkg::RUN_CNT_W-1:0]                run_num;
  logic                                         can_load;
  logic [sdd_pkg::RUN_CNT_W-1:0]                fill;
  sdd_pkg::result_t                             out_ent;

  // request decode and descrambling
  assign seq        = in_tdata[4:0];
  assign d0         = in_tdata[12:5] ^ sdd_pkg::KEY_A;
  assign d1         = in_tdata[20:13] ^ sdd_pkg::KEY_B;
  assign d2         = in_tdata[28:21] ^ sdd_pkg::KEY_C;
  assign in_tready  = can_load;
  assign in_acc     = in_tvalid && in_tready;
  assign odd_frame  = in_acc && seq[0];
  assign even_frame = in_acc && (seq != '0) && !seq[0];

  // header dispatch
  assign is_msg   = (hdr_r >= sdd_pkg::HDR_MSG_FIRST) && (hdr_r <= sdd_pkg::HDR_MSG_LAST);
  assign is_line  = (hdr_r >= sdd_pkg::HDR_LINE_FIRST) && (hdr_r <= sdd_pkg::HDR_LINE_LAST);
  assign msg_emit = even_frame && (hdr_r == sdd_pkg::HDR_MSG_LAST);
  assign line_cnt = hdr_r[2:0];

  // block bytes as seen by an even frame
  always_comb begin
    bb_cur    = bb_r;
    bb_cur[2] = d0;
    bb_cur[3] = d1;
    bb_cur[4] = d2;
  end

  // line byte lanes
  for (genvar g = 0; g < sdd_pkg::NUM_LANES; g++) begin : g_lane
    sdd_lane u_lane (
      .lane_idx (3'(g)),
      .cnt      (line_cnt),
      .ptr      (line_ptr_r),
      .data     (bb_cur[g]),
      .lane     (lanes[g])
    );
  end

  sdd_merge #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_merge (
    .lanes   (lanes),
    .cnt     (line_cnt),
    .ptr     (line_ptr_r),
    .head_in (head_r),
    .upd     (upd)
  );

  // state update
  always_comb begin
    hdr_nxt      = hdr_r;
    bb_nxt       = bb_r;
    msg_nxt      = msg_r;
    line_ptr_nxt = line_ptr_r;
    head_nxt     = head_r;
    if (odd_frame) begin
      hdr_nxt   = d0;
      bb_nxt[0] = d1;
      bb_nxt[1] = d2;
    end
    if (even_frame) begin
      bb_nxt = bb_cur;
      for (int s = 0; s < sdd_pkg::MSG_LEN / sdd_pkg::NUM_LANES; s++) begin
        if (is_msg && (hdr_r[1:0] == 2'(s))) begin
          for (int i = 0; i < sdd_pkg::NUM_LANES; i++) begin
            msg_nxt[s * sdd_pkg::NUM_LANES + i] = bb_cur[i];
          end
        end
      end
      if (is_line) begin
        line_ptr_nxt = upd.ptr;
        head_nxt     = upd.head;
      end
    end
  end

  // result list for this request
  always_comb begin
    run_num = '0;
    for (int k = 0; k < sdd_pkg::RUN_MAX; k++) begin
      run_ent[k].kind = sdd_pkg::KIND_MSG_CHAR;
      run_ent[k].pos  = 8'(k);
      run_ent[k].val  = msg_nxt[k];
      run_ent[k].cls  = sdd_pkg::CLASS_DROPPED;
    end
    if (msg_emit) begin
      run_num = sdd_pkg::RUN_CNT_W'(sdd_pkg::MSG_LEN);
    end else if (even_frame && is_line) begin
      run_num = sdd_pkg::RUN_CNT_W'(upd.num);
      for (int k = 0; k < sdd_pkg::LINE_RUN_MAX; k++) begin
        run_ent[k] = upd.ent[k];
      end
    end
  end

  // deframer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= '0;
      bb_r       <= '0;
      msg_r      <= '0;
      line_ptr_r <= '0;
      head_r     <= '0;
    end else begin
      hdr_r      <= hdr_nxt;
      bb_r       <= bb_nxt;
      msg_r      <= msg_nxt;
      line_ptr_r <= line_ptr_nxt;
      head_r     <= head_nxt;
    end
  end

  sdd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc && (run_num != '0)),
    .load_num   (run_num),
    .load_ent   (run_ent),
    .can_load   (can_load),
    .fill       (fill),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_ent    (out_ent),
    .out_last   (out_tlast)
  );

  // result packing
  assign out_tdata = {6'b0, out_ent.cls, out_ent.val, out_ent.pos};
  assign out_tuser = out_ent.kind;

  // checks
  `SDD_ASSERT_ALWAYS(a_ptr_clamped, line_ptr_r <= 8'(LINE_LIMIT), "line pointer above limit")
  `SDD_ASSERT_NEXT(a_run_loaded, in_acc && (run_num != '0), fill == $past(run_num), "run not loaded")
  `SDD_ASSERT_IMPL(a_end_closes_run, out_tvalid && (out_tuser == sdd_pkg::KIND_LINE_END), out_tlast, "line end not last")
  `SDD_ASSERT_ALWAYS(a_fill_bound, fill <= sdd_pkg::RUN_CNT_W'(sdd_pkg::RUN_MAX), "result buffer overfilled")

endmodule
